/* src/drbr_pkg.sv */
package drbr_pkg;

	// payload widths fixed by the field definitions
	localparam int KIND_W   = 3;
	localparam int SIZE_W   = 16;
	localparam int SLOT_W   = 4;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 2;
	localparam int CD_W     = 4;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TICK      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOST      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RECREATED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DESTROY   = 3'd4;

	// native buffer actions
	localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CREATE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_UPDATE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RECREATE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_DESTROYED = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVER      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOFREE    = 2'd3;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_PLACE = 4'd1;
	localparam logic [SIZE_W-1:0]    CAPACITY_RESET = 16'hFFFF;
	localparam logic                 IN_PLACE_RESET = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] capacity;
		logic              in_place;
	} cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic [ACT_W-1:0]  native_action;
		logic [STAT_W-1:0] status;
	} res_t;

	// native action needed to fill a slot
	function automatic logic [ACT_W-1:0] fill_action(input logic allocated, input logic in_place);
		logic [ACT_W-1:0] act;
		if (!allocated) begin
			act = ACT_CREATE;
		end else if (in_place) begin
			act = ACT_UPDATE;
		end else begin
			act = ACT_RECREATE;
		end
		return act;
	endfunction

endpackage

/* src/drbr_if.sv */
// command channel
interface drbr_req_if;
	logic                        valid;
	logic                        ready;
	logic [drbr_pkg::KIND_W-1:0] kind;
	logic [drbr_pkg::SIZE_W-1:0] data_size;

	modport source (output valid, output kind, output data_size, input ready);
	modport sink (input valid, input kind, input data_size, output ready);
endinterface

// result channel
interface drbr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [drbr_pkg::SLOT_W-1:0] slot_index;
	logic [drbr_pkg::ACT_W-1:0]  native_action;
	logic [drbr_pkg::STAT_W-1:0] status;

	modport source (output valid, output slot_index, output native_action, output status,
		input ready);
	modport sink (input valid, input slot_index, input native_action, input status,
		output ready);
endinterface

// configuration write channel
interface drbr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [drbr_pkg::CFG_IDX_W-1:0] index;
	logic [drbr_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/drbr_core.sv */
module drbr_core #(
	parameter int SLOT_COUNT = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	drbr_req_if.sink       req,
	input  drbr_pkg::cfg_t cfg,
	output logic           res_valid,
	input  logic           res_ready,
	output drbr_pkg::res_t res
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
	localparam logic [drbr_pkg::CD_W-1:0] HOLD_TICKS = drbr_pkg::CD_W'(SLOT_COUNT - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_TICK = 4'b0100,
		S_RES  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [SLOT_COUNT-1:0]         busy_q;
	logic [SLOT_COUNT-1:0]         deferred_q;
	logic [SLOT_COUNT-1:0]         alloc_q;
	logic [drbr_pkg::CD_W-1:0]     cd_q [SLOT_COUNT];
	logic [IDX_W-1:0]              active_q;
	logic                          swap_ok_q;
	logic                          torn_q;
	logic [drbr_pkg::ACT_W-1:0]    act_q;
	logic [drbr_pkg::STAT_W-1:0]   st_q;

	logic [IDX_W-1:0]              fill_idx;
	logic [drbr_pkg::ACT_W-1:0]    fill_act;

	// shared fill unit: the active slot on an in-place write, the scanned slot otherwise
	assign fill_idx = (state_q == S_SCAN) ? cnt_q : active_q;
	assign fill_act = drbr_pkg::fill_action(alloc_q[fill_idx], cfg.in_place);

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RES);
	assign res.slot_index    = drbr_pkg::SLOT_W'(active_q);
	assign res.native_action = act_q;
	assign res.status        = st_q;

	// command sequencer and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			busy_q     <= SLOT_COUNT'(1);
			deferred_q <= '0;
			alloc_q    <= SLOT_COUNT'(1);
			for (int i = 0; i < SLOT_COUNT; i++) begin
				cd_q[i] <= '0;
			end
			active_q   <= '0;
			swap_ok_q  <= 1'b1;
			torn_q     <= 1'b0;
			act_q      <= drbr_pkg::ACT_NONE;
			st_q       <= drbr_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q   <= drbr_pkg::ACT_NONE;
						st_q    <= drbr_pkg::ST_OK;
						cnt_q   <= '0;
						state_q <= S_RES;
						case (req.kind)
							drbr_pkg::KIND_WRITE: begin
								if (torn_q) begin
									st_q <= drbr_pkg::ST_DESTROYED;
								end else if (req.data_size > cfg.capacity) begin
									st_q <= drbr_pkg::ST_OVER;
								end else if (!swap_ok_q) begin
									// swapchain lost: write the active slot in place
									act_q             <= fill_act;
									alloc_q[active_q] <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							drbr_pkg::KIND_TICK: begin
								state_q <= S_TICK;
							end
							drbr_pkg::KIND_LOST: begin
								swap_ok_q <= 1'b0;
							end
							drbr_pkg::KIND_RECREATED: begin
								swap_ok_q <= 1'b1;
							end
							drbr_pkg::KIND_DESTROY: begin
								if (torn_q) begin
									st_q <= drbr_pkg::ST_DESTROYED;
								end else begin
									busy_q     <= '0;
									deferred_q <= '0;
									alloc_q    <= '0;
									for (int i = 0; i < SLOT_COUNT; i++) begin
										cd_q[i] <= '0;
									end
									active_q <= '0;
									torn_q   <= 1'b1;
									act_q    <= drbr_pkg::ACT_RELEASE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// one slot a cycle, lowest free slot wins
					if (!busy_q[cnt_q]) begin
						act_q                <= fill_act;
						alloc_q[cnt_q]       <= 1'b1;
						deferred_q[active_q] <= 1'b1;
						cd_q[active_q]       <= HOLD_TICKS;
						busy_q[cnt_q]        <= 1'b1;
						active_q             <= cnt_q;
						state_q              <= S_RES;
					end else if (cnt_q == LAST_SLOT) begin
						st_q    <= drbr_pkg::ST_NOFREE;
						state_q <= S_RES;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TICK: begin
					// count one deferred slot down per cycle, free it at the end
					if (deferred_q[cnt_q]) begin
						if (cd_q[cnt_q] <= drbr_pkg::CD_W'(1)) begin
							busy_q[cnt_q]     <= 1'b0;
							deferred_q[cnt_q] <= 1'b0;
							cd_q[cnt_q]       <= '0;
						end else begin
							cd_q[cnt_q] <= cd_q[cnt_q] - 1'b1;
						end
					end
					if (cnt_q == LAST_SLOT) begin
						state_q <= S_RES;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// an accepted item drops ready in the cycle after it is taken
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command accepted while previous one still in progress");

	// until teardown the active slot is held and never waits for release
	a_active_held: assert property (@(posedge clk) disable iff (!arst_n)
		!torn_q |-> busy_q[active_q] && !deferred_q[active_q])
		else $error("active slot not busy or deferred");

	// teardown is permanent
	a_torn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(torn_q))
		else $error("teardown flag cleared");

	// a tick pass ends after the last slot
	a_tick_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK && cnt_q == LAST_SLOT |=> state_q == S_RES)
		else $error("tick pass overran the last slot");
`endif

endmodule

/* src/deferred_reuse_buffer_rotator.sv */
// Deferred-reuse buffer rotator: a ring of SLOT_COUNT buffer slots for frames in flight.
// Channels: req carries a command (kind, data_size), rsp returns one result per command
// (slot_index, native_action, status), cfg writes capacity (index 0) or the in-place
// update enable (index 1). All transfer on valid and ready high at a rising edge of clk.
// cfg is always ready; the user must write it only while no command is outstanding,
// which the block does not enforce. Commands are handled one at a time by a sequencer
// that walks the slots with a single shared compare/decrement unit, one slot per cycle:
//   swapchain events, destroy, rejected writes and in-place writes: no slot walk
//   data write with swapchain valid: a scan from slot 0 up to the lowest free slot
//     (over all SLOT_COUNT slots when no slot is free)
//   frame tick: a walk over all SLOT_COUNT slots
// The result goes into the rsp output register once the sequencer finishes and rsp has room.
// A result waiting in rsp does not block the next command; if rsp stalls, that next
// command's result is held in the sequencer and req.ready stays low until rsp frees.
// Reset (arst_n low, asynchronous) makes slot 0 busy, allocated and active, marks the
// swapchain valid, clears teardown and restores capacity 65535 and in-place updates on.
module deferred_reuse_buffer_rotator #(
	parameter int SLOT_COUNT = 4
) (
	input logic      clk,
	input logic      arst_n,
	drbr_req_if.sink req,
	drbr_rsp_if.source rsp,
	drbr_cfg_if.sink cfg
);

	drbr_pkg::cfg_t cfg_q;
	drbr_pkg::res_t res;
	drbr_pkg::res_t rsp_q;
	logic           rsp_valid_q;
	logic           res_valid;
	logic           res_ready;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= drbr_pkg::CAPACITY_RESET;
			cfg_q.in_place <= drbr_pkg::IN_PLACE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				drbr_pkg::REG_CAPACITY: cfg_q.capacity <= cfg.data;
				drbr_pkg::REG_IN_PLACE: cfg_q.in_place <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	drbr_core #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled in the cycle it is taken
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.slot_index    = rsp_q.slot_index;
	assign rsp.native_action = rsp_q.native_action;
	assign rsp.status        = rsp_q.status;

endmodule

/* tb/sv/tb_deferred_reuse_buffer_rotator.sv */
`timescale 1ns / 1ps

module tb_deferred_reuse_buffer_rotator;
	import drbr_pkg::*;

	localparam int SLOT_COUNT = 4;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRESSURE_HOLD = 300;

	// kinds the block ignores, and a register index with no register behind it
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd7;

	// predicts the slot ring and matches results in order
	class slot_ring_board #(int SLOTS = 4);
		logic [SIZE_W-1:0] capacity;
		logic in_place;
		logic busy[SLOTS];
		logic deferred[SLOTS];
		logic [CD_W-1:0] countdown[SLOTS];
		logic allocated[SLOTS];
		logic [SLOT_W-1:0] active;
		logic swap_ok;
		logic torn_down;
		res_t pending_results[$];
		int errors;

		function new();
			capacity = CAPACITY_RESET;
			in_place = IN_PLACE_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				busy[i] = (i == 0);
				deferred[i] = 1'b0;
				countdown[i] = '0;
				allocated[i] = (i == 0);
			end
			active = '0;
			swap_ok = 1'b1;
			torn_down = 1'b0;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("%0t: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return pending_results.size();
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DAT_W-1:0] data);
			if (index == REG_CAPACITY) begin
				capacity = data;
			end else if (index == REG_IN_PLACE) begin
				in_place = data[0];
			end
		endfunction

		// marks a slot allocated and returns the native call it takes
		function logic [ACT_W-1:0] claim_buffer(input int s);
			logic [ACT_W-1:0] act;
			if (!allocated[s]) begin
				act = ACT_CREATE;
			end else if (in_place) begin
				act = ACT_UPDATE;
			end else begin
				act = ACT_RECREATE;
			end
			allocated[s] = 1'b1;
			return act;
		endfunction

		function void note_command(input logic [KIND_W-1:0] kind,
			input logic [SIZE_W-1:0] size);
			res_t r;
			int found;
			r.native_action = ACT_NONE;
			r.status = ST_OK;
			case (kind)
				KIND_WRITE: begin
					if (torn_down) begin
						r.status = ST_DESTROYED;
					end else if (size > capacity) begin
						r.status = ST_OVER;
					end else if (int'(active) >= SLOTS) begin
						r.status = ST_NOFREE;
					end else if (!swap_ok) begin
						r.native_action = claim_buffer(active);
					end else begin
						// lowest free slot becomes active, old one waits out its frames
						found = SLOTS;
						for (int i = SLOTS - 1; i >= 0; i--) begin
							if (!busy[i]) found = i;
						end
						if (found >= SLOTS) begin
							r.status = ST_NOFREE;
						end else begin
							r.native_action = claim_buffer(found);
							deferred[active] = 1'b1;
							countdown[active] = CD_W'(SLOTS - 1);
							busy[found] = 1'b1;
							active = SLOT_W'(found);
						end
					end
				end
				KIND_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (deferred[i]) begin
							if (countdown[i] <= 1) begin
								busy[i] = 1'b0;
								deferred[i] = 1'b0;
								countdown[i] = '0;
							end else begin
								countdown[i] = countdown[i] - 1'b1;
							end
						end
					end
				end
				KIND_LOST: swap_ok = 1'b0;
				KIND_RECREATED: swap_ok = 1'b1;
				KIND_DESTROY: begin
					if (torn_down) begin
						r.status = ST_DESTROYED;
					end else begin
						for (int i = 0; i < SLOTS; i++) begin
							busy[i] = 1'b0;
							deferred[i] = 1'b0;
							countdown[i] = '0;
							allocated[i] = 1'b0;
						end
						active = '0;
						torn_down = 1'b1;
						r.native_action = ACT_RELEASE;
					end
				end
				default: ;
			endcase
			r.slot_index = active;
			pending_results.push_back(r);
		endfunction

		task check_result(input res_t got);
			res_t exp;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing expected: slot %0d action %0d status %0d",
					got.slot_index, got.native_action, got.status));
			end else begin
				exp = pending_results.pop_front();
				if (got.slot_index !== exp.slot_index)
					report($sformatf("slot_index got %0d expected %0d",
						got.slot_index, exp.slot_index));
				if (got.native_action !== exp.native_action)
					report($sformatf("native_action got %0d expected %0d",
						got.native_action, exp.native_action));
				if (got.status !== exp.status)
					report($sformatf("status got %0d expected %0d", got.status, exp.status));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int cycle_count;
	logic calm;
	logic hold_request;
	int stall_left;
	slot_ring_board #(SLOT_COUNT) board;

	drbr_req_if req_ch();
	drbr_rsp_if rsp_ch();
	drbr_cfg_if cfg_ch();

	deferred_reuse_buffer_rotator #(
		.SLOT_COUNT(SLOT_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_deferred_reuse_buffer_rotator: errors");
		$finish;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls, plus one long hold on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request <= 1'b0;
			stall_left <= PRESSURE_HOLD;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			stall_left <= pick_gap();
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		res_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.slot_index = rsp_ch.slot_index;
			got.native_action = rsp_ch.native_action;
			got.status = rsp_ch.status;
			board.check_result(got);
		end
	end

	// one command transfer, then an optional gap
	task send_cmd(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
		input int gap);
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.data_size <= size;
		do @(posedge clk); while (!req_ch.ready);
		board.note_command(kind, size);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one register transfer, then the channel goes idle with valid low
	task write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.write_reg(index, data);
		@(posedge clk);
	endtask

	// wait for every result, then let the sequencer settle
	task drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers, with noise in the unused upper data bits of the in-place flag
	task set_config(input logic [SIZE_W-1:0] cap, input logic in_place);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_IN_PLACE, {15'($urandom), in_place});
	endtask

	// write size: mostly within capacity, some at the edge or beyond
	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		int cap;
		r = $urandom_range(0, 99);
		cap = board.capacity;
		if (r < 65) return SIZE_W'($urandom_range(0, cap));
		if (r < 72) return board.capacity;
		if (r < 85 || cap == 65535) return SIZE_W'($urandom);
		return SIZE_W'($urandom_range(cap + 1, 65535));
	endfunction

	// random frame-like traffic: writes, ticks, few swapchain events, unused kinds, destroy if enabled
	task run_random(input int count, input bit with_destroy);
		int r;
		logic [KIND_W-1:0] kind;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 48) kind = KIND_WRITE;
			else if (r < 82) kind = KIND_TICK;
			else if (r < 87) kind = KIND_LOST;
			else if (r < 95) kind = KIND_RECREATED;
			else if (with_destroy && r < 97) kind = KIND_DESTROY;
			else kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
			send_cmd(kind, pick_size(), pick_gap());
		end
	endtask

	initial begin
		board = new();
		cycle_count = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_TICK;
		req_ch.data_size = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CAPACITY;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot from reset, then run out of free slots
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'hFFFF, pick_gap());
		send_cmd(KIND_WRITE, 16'd100, pick_gap());
		send_cmd(KIND_WRITE, 16'd5, pick_gap());
		// three frames free every deferred slot
		repeat (3) send_cmd(KIND_TICK, 16'hFFFF, pick_gap());
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			send_cmd(KIND_W'(k), 16'h5A5A, pick_gap());
		send_cmd(KIND_WRITE, 16'h8000, pick_gap());
		// lost swapchain writes the active slot in place
		send_cmd(KIND_LOST, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'd10, pick_gap());
		send_cmd(KIND_RECREATED, 16'd0, pick_gap());
		drain();

		// zero capacity, in-place updates off, and a write to no register
		set_config(16'd0, 1'b0);
		write_reg(REG_SPARE, 16'h1234);
		send_cmd(KIND_WRITE, 16'd1, pick_gap());
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		repeat (3) send_cmd(KIND_TICK, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		send_cmd(KIND_LOST, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		send_cmd(KIND_RECREATED, 16'd0, pick_gap());
		drain();

		// random phases over several settings
		set_config(16'hFFFF, 1'b1);
		run_random(250, 1'b0);
		drain();

		set_config(16'd0, 1'b0);
		run_random(250, 1'b0);
		drain();

		calm = 1'b1;
		set_config(SIZE_W'($urandom_range(1, 65534)), 1'b1);
		run_random(250, 1'b0);
		drain();
		calm = 1'b0;

		// result side holds off while commands keep coming
		set_config(16'd1, 1'b0);
		hold_request <= 1'b1;
		calm = 1'b1;
		run_random(60, 1'b0);
		calm = 1'b0;
		run_random(190, 1'b0);
		drain();

		set_config(SIZE_W'($urandom), 1'($urandom));
		run_random(250, 1'b0);
		drain();

		// teardown near the end: nothing can be written afterwards
		set_config(16'hFFFF, 1'b0);
		run_random(200, 1'b0);
		send_cmd(KIND_DESTROY, 16'd0, pick_gap());
		send_cmd(KIND_DESTROY, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		send_cmd(KIND_LOST, 16'd0, pick_gap());
		send_cmd(KIND_WRITE, 16'd0, pick_gap());
		send_cmd(KIND_RECREATED, 16'd0, pick_gap());
		send_cmd(KIND_TICK, 16'd0, pick_gap());
		run_random(40, 1'b1);
		drain();

		if (board.pending() != 0) board.report("results never arrived");
		if (board.errors == 0) begin
			$display("tb_deferred_reuse_buffer_rotator: clean");
		end else begin
			$display("tb_deferred_reuse_buffer_rotator: errors");
		end
		$finish;
	end

endmodule
